// File: sv/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants for the stepper oscillating sweep
// Command and result payloads, register indexes, reset values and the
// half-step coil sequence.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);

  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COIL_W  = 4;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(360);

  localparam logic [ANGLE_W-1:0] LOWER_LIMIT_RST = ANGLE_W'(30);
  localparam logic [ANGLE_W-1:0] UPPER_LIMIT_RST = ANGLE_W'(150);
  localparam logic [STEP_W-1:0]  STEPS_PER_DEG_RST = STEP_W'(12);
  localparam logic [TICK_W-1:0]  SWEEP_TICKS_RST = TICK_W'(10000);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_LOAD  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_LOWER_LIMIT   = 2'd0,
    CFG_UPPER_LIMIT   = 2'd1,
    CFG_STEPS_PER_DEG = 2'd2,
    CFG_SWEEP_TICKS   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ANGLE_W-1:0] angle_value;
  } req_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coil_pattern;
    logic               coil_update;
    logic [ANGLE_W-1:0] angle_deg;
    logic               moving_up;
    logic               running;
  } res_t;

  // Half-step sequence, coil A in bit 0
  function automatic logic [COIL_W-1:0] phase_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// File: sv/stepper_oscillating_sweep.sv
// ----------------------------------------------------------------------------
// stepper_oscillating_sweep: half-step stepper sequencer with angle sweep
// Takes tick, start, stop and load-angle commands and returns one result
// per command with the coil pattern and the tracked sweep state.
// ----------------------------------------------------------------------------
// Each command updates the sweep state through a single level of counter
// and compare logic at the clock edge that accepts it; the result is
// registered at that same edge, into the result register or, while that
// is held, into the skid register. A two-entry output buffer (result
// register plus skid register) lets a new command be accepted every cycle
// until both entries are full; req_stall rises only when both entries
// hold results. Config registers are written through the cfg port, which
// is always ready, and must be written only while no command is in flight.
module stepper_oscillating_sweep (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  sos_pkg::req_t          req,
  output logic                   res_valid,
  input  logic                   res_stall,
  output sos_pkg::res_t          res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import sos_pkg::*;

  // configuration
  logic [ANGLE_W-1:0] lower_limit;
  logic [ANGLE_W-1:0] upper_limit;
  logic [STEP_W-1:0]  steps_per_deg;
  logic [TICK_W-1:0]  sweep_ticks;

  // sweep state
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic [STEP_W-1:0]  step_count, step_count_next;
  logic [ANGLE_W-1:0] angle, angle_next;
  logic               direction_up, direction_up_next;
  logic               sweep_active, sweep_active_next;

  // output buffer
  res_t res_q, skid_q;
  logic res_q_valid, skid_valid;
  res_t result;

  logic accept;
  logic out_fire;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_idx;
  logic [STEP_W-1:0]  step_inc;
  logic [STEP_W-1:0]  spd_eff;
  logic               degree_hit;
  logic [ANGLE_W-1:0] angle_stepped;
  logic [TICK_W-1:0]  tick_inc;
  logic               tick_run;

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign res_valid = res_q_valid;
  assign res       = res_q;
  assign out_fire  = res_q_valid && !res_stall;

  always_comb begin
    phase     = tick_count[PHASE_W-1:0];
    // falling sweep walks the table backward
    phase_idx = direction_up ? phase : ~phase;
    step_inc  = step_count + STEP_W'(1);
    spd_eff   = (steps_per_deg == '0) ? STEP_W'(1) : steps_per_deg;
    degree_hit = step_inc >= spd_eff;
    tick_inc  = tick_count + TICK_W'(1);
    tick_run  = (req_type_t'(req.req_type) == REQ_TICK) && sweep_active;

    angle_stepped = angle;
    if (degree_hit) begin
      if (direction_up) begin
        if (angle < ANGLE_MAX) angle_stepped = angle + ANGLE_W'(1);
      end else begin
        if (angle != '0) angle_stepped = angle - ANGLE_W'(1);
      end
    end

    tick_count_next   = tick_count;
    step_count_next   = step_count;
    angle_next        = angle;
    direction_up_next = direction_up;
    sweep_active_next = sweep_active;

    unique case (req_type_t'(req.req_type))
      REQ_TICK: begin
        if (sweep_active) begin
          step_count_next = degree_hit ? '0 : step_inc;
          angle_next      = angle_stepped;
          if (direction_up) begin
            if (angle_stepped >= upper_limit) direction_up_next = 1'b0;
          end else begin
            if (angle_stepped <= lower_limit) direction_up_next = 1'b1;
          end
          tick_count_next = tick_inc;
          if (tick_inc >= sweep_ticks) sweep_active_next = 1'b0;
        end
      end
      REQ_START: begin
        sweep_active_next = 1'b1;
        tick_count_next   = '0;
        step_count_next   = '0;
      end
      REQ_STOP: begin
        sweep_active_next = 1'b0;
      end
      REQ_LOAD: begin
        angle_next = (req.angle_value > ANGLE_MAX) ? ANGLE_MAX : req.angle_value;
      end
      default: begin
      end
    endcase

    result.coil_pattern = tick_run ? phase_pattern(phase_idx) : '0;
    result.coil_update  = tick_run;
    result.angle_deg    = angle_next;
    result.moving_up    = direction_up_next;
    result.running      = sweep_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit   <= LOWER_LIMIT_RST;
      upper_limit   <= UPPER_LIMIT_RST;
      steps_per_deg <= STEPS_PER_DEG_RST;
      sweep_ticks   <= SWEEP_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LOWER_LIMIT:   lower_limit   <= cfg_data[ANGLE_W-1:0];
        CFG_UPPER_LIMIT:   upper_limit   <= cfg_data[ANGLE_W-1:0];
        CFG_STEPS_PER_DEG: steps_per_deg <= cfg_data[STEP_W-1:0];
        CFG_SWEEP_TICKS:   sweep_ticks   <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      step_count   <= '0;
      angle        <= '0;
      direction_up <= 1'b0;
      sweep_active <= 1'b0;
    end else if (accept) begin
      tick_count   <= tick_count_next;
      step_count   <= step_count_next;
      angle        <= angle_next;
      direction_up <= direction_up_next;
      sweep_active <= sweep_active_next;
    end
  end

  // result register refills from skid first, so order is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (out_fire || !res_q_valid) begin
        res_q_valid <= skid_valid || accept;
        skid_valid  <= skid_valid && accept;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !res_q_valid) begin
      res_q <= skid_valid ? skid_q : result;
      if (skid_valid && accept) skid_q <= result;
    end else if (accept) begin
      skid_q <= result;
    end
  end

endmodule

// File: tb/stepper_oscillating_sweep_tb.sv
// ----------------------------------------------------------------------------
// stepper_oscillating_sweep_tb: self-checking bench for the half-step sweep
// Runs a short directed table and then randomized start/tick/load bursts
// under several limit, step-rate and sweep-length settings. Every command
// result is checked against its pinned expectation or an in-bench sweep
// predictor, with random sender gaps and receiver stalls in most phases.
// ----------------------------------------------------------------------------
module stepper_oscillating_sweep_tb;
  import sos_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned PHASES = 8;
  // Half-step coil sequence, entry 0 in the low nibble
  localparam logic [31:0] COIL_SEQ = 32'h9_8_C_4_6_2_3_1;

  typedef struct packed {
    req_type_t          kind;
    logic [ANGLE_W-1:0] val;
    logic               fixed;
    res_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Pinned expectation that travels with the current command
  logic row_fixed = 1'b0;
  res_t row_want = '0;

  int unsigned send_gap_pct = 9;
  int unsigned hold_pct = 61;
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned idle_cycles = 0;

  // Predictor copy of the sweep state and its registers
  logic [TICK_W-1:0]  sw_ticks = '0;
  logic [STEP_W-1:0]  sw_steps = '0;
  logic [ANGLE_W-1:0] sw_angle = '0;
  logic               sw_up = 1'b0;
  logic               sw_active = 1'b0;
  logic [ANGLE_W-1:0] cf_lower = LOWER_LIMIT_RST;
  logic [ANGLE_W-1:0] cf_upper = UPPER_LIMIT_RST;
  logic [STEP_W-1:0]  cf_spd = STEPS_PER_DEG_RST;
  logic [TICK_W-1:0]  cf_ticks = SWEEP_TICKS_RST;

  res_t sweep_due[$];
  row_t plan[$];

  stepper_oscillating_sweep dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic res_t sweep_predict(input req_t cmd);
    res_t o;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] idx;
    o = '0;
    case (req_type_t'(cmd.req_type))
      REQ_TICK: begin
        if (sw_active) begin
          ph = sw_ticks[PHASE_W-1:0];
          idx = sw_up ? ph : PHASE_W'(PHASE_COUNT - 1) - ph;
          o.coil_pattern = COIL_SEQ[{idx, 2'b00} +: COIL_W];
          o.coil_update = 1'b1;
          sw_steps = sw_steps + STEP_W'(1);
          if (sw_steps >= cf_spd) begin
            sw_steps = '0;
            if (sw_up) begin
              if (sw_angle < ANGLE_MAX) sw_angle = sw_angle + ANGLE_W'(1);
            end else if (sw_angle != '0) begin
              sw_angle = sw_angle - ANGLE_W'(1);
            end
          end
          // Turn round on the direction in force before this tick
          if (sw_up) begin
            if (sw_angle >= cf_upper) sw_up = 1'b0;
          end else if (sw_angle <= cf_lower) begin
            sw_up = 1'b1;
          end
          sw_ticks = sw_ticks + TICK_W'(1);
          if (sw_ticks >= cf_ticks) sw_active = 1'b0;
        end
      end
      REQ_START: begin
        sw_active = 1'b1;
        sw_ticks = '0;
        sw_steps = '0;
      end
      REQ_STOP: sw_active = 1'b0;
      default: sw_angle = (cmd.angle_value > ANGLE_MAX) ? ANGLE_MAX : cmd.angle_value;
    endcase
    o.angle_deg = sw_angle;
    o.moving_up = sw_up;
    o.running = sw_active;
    return o;
  endfunction

  task automatic flag_field(input string what, input logic [15:0] got,
                            input logic [15:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 50)
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t guess;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_LOWER_LIMIT:   cf_lower = cfg_data[ANGLE_W-1:0];
          CFG_UPPER_LIMIT:   cf_upper = cfg_data[ANGLE_W-1:0];
          CFG_STEPS_PER_DEG: cf_spd = cfg_data[STEP_W-1:0];
          default:           cf_ticks = cfg_data[TICK_W-1:0];
        endcase
      end
      if (res_valid && !res_stall) begin
        if (sweep_due.size() == 0) begin
          flag_field("result with no command pending", res, ~res);
        end else begin
          want = sweep_due.pop_front();
          flag_field("coil_pattern", 16'(res.coil_pattern), 16'(want.coil_pattern));
          flag_field("coil_update", 16'(res.coil_update), 16'(want.coil_update));
          flag_field("angle_deg", 16'(res.angle_deg), 16'(want.angle_deg));
          flag_field("moving_up", 16'(res.moving_up), 16'(want.moving_up));
          flag_field("running", 16'(res.running), 16'(want.running));
        end
      end
      if (req_valid && !req_stall) begin
        sent_items++;
        guess = sweep_predict(req);
        sweep_due.push_back(row_fixed ? row_want : guess);
      end
    end
  end

  // Receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    res_stall <= (hold_pct != 0) && ($urandom_range(99) < hold_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_cmd(input req_type_t kind, input logic [ANGLE_W-1:0] val,
                          input logic fixed, input res_t want);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= {kind, val};
    row_fixed <= fixed;
    row_want <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_sweep(input int unsigned lower, input int unsigned upper,
                               input int unsigned spd, input int unsigned ticks);
    cfg_write(CFG_LOWER_LIMIT, 16'(lower));
    cfg_write(CFG_UPPER_LIMIT, 16'(upper));
    cfg_write(CFG_STEPS_PER_DEG, 16'(spd));
    cfg_write(CFG_SWEEP_TICKS, 16'(ticks));
  endtask

  // Favor angles just around the active limits so turn-rounds happen often
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int r;
    int a;
    r = $urandom_range(9);
    if (r < 4) begin
      a = int'(r[0] ? cf_lower : cf_upper) + int'($urandom_range(8)) - 4;
      if (a < 0) a = 0;
      if (a > 511) a = 511;
      return ANGLE_W'(a);
    end
    if (r < 8) return ANGLE_W'($urandom_range(360));
    return ANGLE_W'($urandom_range(511));
  endfunction

  function automatic row_t mk_row(input req_type_t kind, input logic [ANGLE_W-1:0] val,
                                  input logic fixed, input res_t want);
    row_t r;
    r.kind = kind;
    r.val = val;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  initial begin
    row_t row;
    int unsigned goal;
    int unsigned burst;

    // Directed table at reset settings: limits 30/150, 12 steps per degree
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b1, {4'h0, 1'b0, 9'd0,   1'b0, 1'b0}));
    plan.push_back(mk_row(REQ_LOAD,  9'd511, 1'b1, {4'h0, 1'b0, 9'd360, 1'b0, 1'b0}));
    plan.push_back(mk_row(REQ_STOP,  9'd0,   1'b1, {4'h0, 1'b0, 9'd360, 1'b0, 1'b0}));
    plan.push_back(mk_row(REQ_LOAD,  9'd0,   1'b1, {4'h0, 1'b0, 9'd0,   1'b0, 1'b0}));
    plan.push_back(mk_row(REQ_LOAD,  9'd100, 1'b1, {4'h0, 1'b0, 9'd100, 1'b0, 1'b0}));
    plan.push_back(mk_row(REQ_START, 9'd511, 1'b1, {4'h0, 1'b0, 9'd100, 1'b0, 1'b1}));
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b1, {4'h9, 1'b1, 9'd100, 1'b0, 1'b1}));
    plan.push_back(mk_row(REQ_TICK,  9'd511, 1'b1, {4'h8, 1'b1, 9'd100, 1'b0, 1'b1}));
    plan.push_back(mk_row(REQ_LOAD,  9'd20,  1'b1, {4'h0, 1'b0, 9'd20,  1'b0, 1'b1}));
    for (int i = 0; i < 5; i++) plan.push_back(mk_row(REQ_TICK, 9'd0, 1'b0, '0));
    plan.push_back(mk_row(REQ_START, 9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_LOAD,  9'd150, 1'b0, '0));
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_STOP,  9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_TICK,  9'd0,   1'b0, '0));
    plan.push_back(mk_row(REQ_LOAD,  9'd361, 1'b0, '0));
    plan.push_back(mk_row(REQ_LOAD,  9'd256, 1'b0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      send_cmd(row.kind, row.val, row.fixed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        send_gap_pct = 61;
        hold_pct = 9;
      end else if (ph == 6) begin
        send_gap_pct = 0;
        hold_pct = 0;
      end
      if (ph != 0) begin
        // Drain before touching the registers
        req_valid <= 1'b0;
        while (sweep_due.size() != 0) @(negedge clk);
        case (ph)
          1: program_sweep(0, 360, 1, 65535);
          2: program_sweep(100, 104, 1, 40);
          3: program_sweep(360, 0, 2, 300);
          4: program_sweep(0, 511, 0, 0);
          5: program_sweep(45, 47, 3, 1);
          6: program_sweep(200, 210, 255, 65535);
          default: program_sweep($urandom_range(360), $urandom_range(360),
                                 $urandom_range(1, 8), $urandom_range(1, 500));
        endcase
      end
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(1) == 1) send_cmd(REQ_LOAD, pick_angle(), 1'b0, '0);
          send_cmd(REQ_START, ANGLE_W'($urandom), 1'b0, '0);
          burst = ($urandom_range(4) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 60);
          for (int k = 0; k < burst; k++) begin
            if ($urandom_range(19) == 0) send_cmd(REQ_LOAD, pick_angle(), 1'b0, '0);
            else send_cmd(REQ_TICK, ANGLE_W'($urandom), 1'b0, '0);
          end
          if ($urandom_range(2) == 0) send_cmd(REQ_STOP, ANGLE_W'($urandom), 1'b0, '0);
        end else begin
          send_cmd(req_type_t'($urandom_range(3)), ANGLE_W'($urandom), 1'b0, '0);
        end
      end
    end

    req_valid <= 1'b0;
    while (sweep_due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    flag_field("results never returned", 16'(sweep_due.size()), 16'd0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
